// ===== rtl/core/qstg_pkg.sv =====
// ----------------------------------------------------------------------------
// qstg_pkg
// Types and constants shared by the quadratic step time generator.
// ----------------------------------------------------------------------------
`default_nettype none

package qstg_pkg;

	// command checks
	localparam logic signed [15:0] INC_LIMIT        = 16'sh7FFF;
	localparam logic signed [15:0] INC_LIMIT_NEG    = -16'sh7FFF;
	localparam logic signed [15:0] INC_CHG_LIMIT    = 16'sh0FFF;
	localparam logic signed [15:0] INC_CHG_LIMIT_NEG = -16'sh0FFF;
	localparam logic [15:0]        COUNT_LIMIT      = 16'h7FFF;
	localparam logic signed [7:0]  SHIFT_MAX        = 8'sd16;
	localparam logic signed [7:0]  SHIFT_MIN        = -8'sd8;
	localparam logic signed [7:0]  SHIFT_FRAC8      = 8'sd8;

	// fractional accumulator presets (one half)
	localparam logic [15:0] HALF16 = 16'h8000;
	localparam logic [15:0] HALF8  = 16'h0080;

	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_NO_MOVE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FM_WHOLE  = 2'd0,
		FM_FRAC8  = 2'd1,
		FM_FRAC16 = 2'd2
	} frac_mode_t;

	typedef struct packed {
		action_t            action;
		logic [31:0]        move_interval;
		logic [15:0]        move_count;
		logic signed [15:0] move_add;
		logic signed [15:0] move_add_second;
		logic signed [7:0]  move_shift;
	} cmd_t;

	typedef struct packed {
		logic [31:0] step_time;
		status_t     status;
		logic        end_of_move;
	} result_t;

	typedef struct packed {
		logic [31:0] interval;
		logic [31:0] inc;
		logic [31:0] inc_chg;
		logic [15:0] frac;
		frac_mode_t  mode;
		logic [31:0] time_acc;
		logic [15:0] steps_left;
	} move_state_t;

	typedef struct packed {
		logic        bad;
		logic [31:0] interval;
		logic [31:0] inc;
		logic [31:0] inc_chg;
		logic [15:0] frac;
		frac_mode_t  mode;
	} load_t;

	typedef struct packed {
		logic [31:0] interval;
		logic [31:0] inc;
		logic [15:0] frac;
		logic [31:0] time_acc;
		logic [15:0] steps_left;
		logic        overflow;
		logic        last;
	} step_t;

endpackage

`default_nettype wire

// ===== rtl/core/qstg_in_if.sv =====
// ----------------------------------------------------------------------------
// qstg_in_if
// Command request channel: valid/ready handshake with a command payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface qstg_in_if;
	import qstg_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qstg_out_if.sv =====
// ----------------------------------------------------------------------------
// qstg_out_if
// Result request channel: valid/ready handshake with a result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface qstg_out_if;
	import qstg_pkg::*;

	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/qstg_load.sv =====
// ----------------------------------------------------------------------------
// qstg_load
// Checks a move command and brings interval, add and add2 to one scale.
// ----------------------------------------------------------------------------
`default_nettype none

module qstg_load (
	input  qstg_pkg::cmd_t  cmd,
	output qstg_pkg::load_t ld
);
	import qstg_pkg::*;

	logic [3:0]  k;
	logic [7:0]  neg_sh;
	logic [7:0]  d16;
	logic [7:0]  d8;
	logic [31:0] add_ext;
	logic [31:0] add2_ext;

	assign neg_sh   = 8'(-cmd.move_shift);
	assign d16      = 8'(SHIFT_MAX - cmd.move_shift);
	assign d8       = 8'(SHIFT_FRAC8 - cmd.move_shift);
	assign add_ext  = {{16{cmd.move_add[15]}}, cmd.move_add};
	assign add2_ext = {{16{cmd.move_add_second[15]}}, cmd.move_add_second};

	always_comb begin
		ld.bad = (cmd.move_count == 16'd0)
			|| (cmd.move_interval == 32'd0 && cmd.move_add == 16'sd0
				&& cmd.move_add_second == 16'sd0 && cmd.move_count > 16'd1)
			|| cmd.move_interval[31]
			|| (cmd.move_count > COUNT_LIMIT)
			|| (cmd.move_add < INC_LIMIT_NEG) || (cmd.move_add > INC_LIMIT)
			|| (cmd.move_add_second < INC_CHG_LIMIT_NEG)
			|| (cmd.move_add_second > INC_CHG_LIMIT)
			|| (cmd.move_shift > SHIFT_MAX) || (cmd.move_shift < SHIFT_MIN);

		if (cmd.move_shift <= 8'sd0) begin
			k       = neg_sh[3:0];
			ld.mode = FM_WHOLE;
			ld.frac = 16'd0;
		end else if (cmd.move_shift > SHIFT_FRAC8) begin
			k       = d16[3:0];
			ld.mode = FM_FRAC16;
			ld.frac = HALF16;
		end else begin
			k       = d8[3:0];
			ld.mode = FM_FRAC8;
			ld.frac = HALF8;
		end

		ld.interval = cmd.move_interval << k;
		ld.inc      = add_ext << k;
		ld.inc_chg  = add2_ext << k;
	end
endmodule

`default_nettype wire

// ===== rtl/core/qstg_advance.sv =====
// ----------------------------------------------------------------------------
// qstg_advance
// One step: time += interval (with fraction carry), then the quadratic update.
// ----------------------------------------------------------------------------
`default_nettype none

module qstg_advance (
	input  qstg_pkg::move_state_t st,
	output qstg_pkg::step_t       nx
);
	import qstg_pkg::*;

	logic [31:0] sum;
	logic [15:0] steps_dec;

	assign sum       = st.interval + {16'd0, st.frac};
	assign steps_dec = st.steps_left - 16'd1;

	always_comb begin
		case (st.mode)
			FM_FRAC16: begin
				nx.time_acc = st.time_acc + {16'd0, sum[31:16]};
				nx.frac     = sum[15:0];
			end
			FM_FRAC8: begin
				nx.time_acc = st.time_acc + {8'd0, sum[31:8]};
				nx.frac     = {8'd0, sum[7:0]};
			end
			default: begin
				nx.time_acc = st.time_acc + st.interval;
				nx.frac     = st.frac;
			end
		endcase

		nx.interval = st.interval + st.inc;
		nx.inc      = st.inc + st.inc_chg;
		// interval of 2^31 or more ends the move
		nx.overflow = nx.interval[31];
		nx.steps_left = nx.overflow ? 16'd0 : steps_dec;
		nx.last       = nx.overflow || (steps_dec == 16'd0);
	end
endmodule

`default_nettype wire

// ===== rtl/core/quadratic_step_time_generator_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_step_time_generator_core
// Expands stepper move commands into step times from the move start.
// ----------------------------------------------------------------------------
// Every request on cmd gives exactly one request on res. A load request checks
// the move and answers status ok or invalid; each advance request answers the
// next step time, with end_of_move set on the final step or on interval
// overflow, or status "no active move" when none is loaded. One request is
// taken per cycle while res is not stalled; a result passes the input
// register, then the step update into the result register, and the move
// state is updated in the same cycle so the next request sees it at once.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_step_time_generator_core (
	input  wire        clk,
	input  wire        arst_n,
	qstg_in_if.sink    cmd,
	qstg_out_if.source res
);
	import qstg_pkg::*;

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        fire_s1;
	move_state_t state_q;
	move_state_t state_nx;
	logic        out_valid_q;
	result_t     out_q;
	result_t     result;
	load_t       ld;
	step_t       nx;

	qstg_load u_load (
		.cmd (cmd_s1),
		.ld  (ld)
	);

	qstg_advance u_advance (
		.st (state_q),
		.nx (nx)
	);

	assign fire_s1   = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || fire_s1;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	always_comb begin
		state_nx = state_q;
		result   = '{step_time: 32'd0, status: ST_OK, end_of_move: 1'b0};
		case (cmd_s1.action)
			ACT_LOAD: begin
				if (ld.bad) begin
					state_nx.steps_left = 16'd0;
					result.status       = ST_INVALID;
				end else begin
					state_nx.interval   = ld.interval;
					state_nx.inc        = ld.inc;
					state_nx.inc_chg    = ld.inc_chg;
					state_nx.frac       = ld.frac;
					state_nx.mode       = ld.mode;
					state_nx.time_acc   = 32'd0;
					state_nx.steps_left = cmd_s1.move_count;
				end
			end
			ACT_ADVANCE: begin
				if (state_q.steps_left == 16'd0) begin
					result.status = ST_NO_MOVE;
				end else begin
					state_nx.interval   = nx.interval;
					state_nx.inc        = nx.inc;
					state_nx.frac       = nx.frac;
					state_nx.time_acc   = nx.time_acc;
					state_nx.steps_left = nx.steps_left;
					result.step_time    = nx.time_acc;
					result.status       = nx.overflow ? ST_OVERFLOW : ST_OK;
					result.end_of_move  = nx.last;
				end
			end
			default: begin
				result.status = ST_NO_MOVE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{interval: 32'd0, inc: 32'd0, inc_chg: 32'd0, frac: 16'd0,
				mode: FM_WHOLE, time_acc: 32'd0, steps_left: 16'd0};
			out_valid_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				state_q     <= state_nx;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_q <= result;
		end
	end
endmodule

`default_nettype wire
